// ===== hdl/mrsd_pkg.sv =====
`default_nettype none
package mrsd_pkg;

   // field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned DATA_W  = 7;
   localparam int unsigned CHAN_W  = 4;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned CTRL_W  = 7;

   // configuration register indexes
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 7;
   localparam logic [CSR_ADDR_W-1:0] CSR_OMNI_MODE       = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LISTEN_CHANNEL  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAVEFORM_CTRL   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CUTOFF_CTRL     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESONANCE_CTRL  = 3'd4;

   // configuration reset values
   localparam logic              OMNI_RESET       = 1'b1;
   localparam logic [CHAN_W-1:0] LISTEN_RESET     = 4'd0;
   localparam logic [CTRL_W-1:0] WAVEFORM_RESET   = 7'd74;
   localparam logic [CTRL_W-1:0] CUTOFF_RESET     = 7'd71;
   localparam logic [CTRL_W-1:0] RESONANCE_RESET  = 7'd72;

   // status high nibbles
   localparam logic [3:0] STATUS_NOTE_OFF  = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON   = 4'h9;
   localparam logic [3:0] STATUS_CTRL      = 4'hB;
   localparam logic [3:0] STATUS_PROGRAM   = 4'hC;
   localparam logic [3:0] STATUS_PRESSURE  = 4'hD;
   localparam logic [3:0] STATUS_SYSTEM    = 4'hF;

   localparam logic [CTRL_W-1:0] CC_ALL_NOTES_OFF = 7'h7B;
   localparam logic [DATA_W-1:0] BAND_SQUARE      = 7'd43;
   localparam logic [DATA_W-1:0] BAND_TRIANGLE    = 7'd85;

   localparam logic [DATA_W-1:0] WAVE_SAW   = 7'd0;
   localparam logic [DATA_W-1:0] WAVE_PULSE = 7'd1;
   localparam logic [DATA_W-1:0] WAVE_TRI   = 7'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_NOTE_OFF  = 3'd0,
      KIND_NOTE_ON   = 3'd1,
      KIND_WAVEFORM  = 3'd2,
      KIND_CUTOFF    = 3'd3,
      KIND_RESONANCE = 3'd4,
      KIND_ALL_OFF   = 3'd5
   } event_kind_type;

   // lowest bits first: kind, channel, note, value
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] note;
      logic [CHAN_W-1:0] chan;
      event_kind_type    kind;
   } event_type;

   localparam int unsigned EVENT_W  = $bits(event_type);
   localparam int unsigned RSP_W    = ((EVENT_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// ===== hdl/midi_running_status_decoder.sv =====
`default_nettype none
// channel   | dir | handshake            | payload
// req       | in  | req_tvalid/tready    | tdata[7:0] midi_byte
// rsp       | out | rsp_tvalid/tready    | tdata kind, channel, note, value
// csr       | in  | csr_we, no wait      | csr_addr index, csr_wdata value
//
// one byte per cycle sustained unless a result stalls: a byte is captured in the
// input register, decoded combinationally against the running status, and any
// event lands in the result register, which decouples the two sides
// bytes that give no event drain even while a result is stalled
// a byte that gives an event waits in the input register while the result stalls
// reset clears running status, data count and valid flags and restores default config
module midi_running_status_decoder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // slave stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [7:0] midi_byte
   // master stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [2:0] event_kind, [6:3] event_channel, [13:7] note_number,
   // [20:14] event_value, [23:21] zero
   output logic [mrsd_pkg::RSP_W-1:0]             rsp_tdata,
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [mrsd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [mrsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers
   logic                              omni_ff;
   logic [mrsd_pkg::CHAN_W-1:0]       listen_ff;
   logic [mrsd_pkg::CTRL_W-1:0]       wave_cc_ff;
   logic [mrsd_pkg::CTRL_W-1:0]       cutoff_cc_ff;
   logic [mrsd_pkg::CTRL_W-1:0]       reso_cc_ff;

   // input register
   logic                              in_valid_ff;
   logic [mrsd_pkg::BYTE_W-1:0]       in_byte_ff;

   // parser state
   logic [mrsd_pkg::BYTE_W-1:0]       status_ff, status_in;
   logic [mrsd_pkg::DATA_W-1:0]       first_ff, first_in;
   logic                              count_ff, count_in;   // one data byte held
   logic                              two_ff, two_in;       // message needs two bytes

   // result register
   logic                              out_valid_ff;
   mrsd_pkg::event_type               evt_ff, evt_in;

   logic                              fire;       // decoded byte gives an event
   logic                              decode_en;  // message completes this byte
   logic [mrsd_pkg::DATA_W-1:0]       d0, d1;
   logic                              chan_ok;
   logic                              advance;

   // a byte moves on when the result slot is free or it brings no event
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready || !fire);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(mrsd_pkg::RSP_W - mrsd_pkg::EVENT_W){1'b0}}, evt_ff};

   assign chan_ok = omni_ff || (status_ff[3:0] == listen_ff);

   // running status bookkeeping
   always_comb begin
      status_in = status_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      two_in    = two_ff;
      decode_en = 1'b0;
      d0        = '0;
      d1        = '0;
      if (in_byte_ff[7]) begin
         // system bytes leave everything alone
         if (in_byte_ff[7:4] != mrsd_pkg::STATUS_SYSTEM) begin
            status_in = in_byte_ff;
            count_in  = 1'b0;
            two_in    = !((in_byte_ff[7:4] == mrsd_pkg::STATUS_PROGRAM) ||
                          (in_byte_ff[7:4] == mrsd_pkg::STATUS_PRESSURE));
         end
      end else if (status_ff != '0) begin
         if (!count_ff) begin
            first_in = in_byte_ff[6:0];
            if (two_ff) begin
               count_in = 1'b1;
            end else begin
               decode_en = 1'b1;
               d0        = in_byte_ff[6:0];
            end
         end else begin
            count_in  = 1'b0;
            decode_en = 1'b1;
            d0        = first_ff;
            d1        = in_byte_ff[6:0];
         end
      end
   end

   // message to event
   always_comb begin
      fire        = 1'b0;
      evt_in      = '0;
      evt_in.chan = status_ff[3:0];
      evt_in.kind = mrsd_pkg::KIND_NOTE_OFF;
      unique case (status_ff[7:4])
         mrsd_pkg::STATUS_NOTE_ON: begin
            fire        = 1'b1;
            evt_in.note = d0;
            evt_in.value = d1;
            // zero velocity counts as release
            evt_in.kind = (d1 == '0) ? mrsd_pkg::KIND_NOTE_OFF : mrsd_pkg::KIND_NOTE_ON;
         end
         mrsd_pkg::STATUS_NOTE_OFF: begin
            fire         = 1'b1;
            evt_in.note  = d0;
            evt_in.value = d1;
            evt_in.kind  = mrsd_pkg::KIND_NOTE_OFF;
         end
         mrsd_pkg::STATUS_CTRL: begin
            // waveform wins over cutoff over resonance over all-notes-off
            if (d0 == wave_cc_ff) begin
               fire        = 1'b1;
               evt_in.kind = mrsd_pkg::KIND_WAVEFORM;
               if (d1 < mrsd_pkg::BAND_SQUARE) begin
                  evt_in.value = mrsd_pkg::WAVE_SAW;
               end else if (d1 < mrsd_pkg::BAND_TRIANGLE) begin
                  evt_in.value = mrsd_pkg::WAVE_PULSE;
               end else begin
                  evt_in.value = mrsd_pkg::WAVE_TRI;
               end
            end else if (d0 == cutoff_cc_ff) begin
               fire         = 1'b1;
               evt_in.kind  = mrsd_pkg::KIND_CUTOFF;
               evt_in.value = d1;
            end else if (d0 == reso_cc_ff) begin
               fire         = 1'b1;
               evt_in.kind  = mrsd_pkg::KIND_RESONANCE;
               evt_in.value = d1;
            end else if (d0 == mrsd_pkg::CC_ALL_NOTES_OFF) begin
               fire        = 1'b1;
               evt_in.kind = mrsd_pkg::KIND_ALL_OFF;
            end
         end
         default: begin
            fire = 1'b0;
         end
      endcase
      // no event unless a message completes on an accepted channel
      if (!decode_en || !chan_ok) begin
         fire = 1'b0;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         omni_ff      <= mrsd_pkg::OMNI_RESET;
         listen_ff    <= mrsd_pkg::LISTEN_RESET;
         wave_cc_ff   <= mrsd_pkg::WAVEFORM_RESET;
         cutoff_cc_ff <= mrsd_pkg::CUTOFF_RESET;
         reso_cc_ff   <= mrsd_pkg::RESONANCE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            mrsd_pkg::CSR_OMNI_MODE:      omni_ff      <= csr_wdata[0];
            mrsd_pkg::CSR_LISTEN_CHANNEL: listen_ff    <= csr_wdata[mrsd_pkg::CHAN_W-1:0];
            mrsd_pkg::CSR_WAVEFORM_CTRL:  wave_cc_ff   <= csr_wdata;
            mrsd_pkg::CSR_CUTOFF_CTRL:    cutoff_cc_ff <= csr_wdata;
            mrsd_pkg::CSR_RESONANCE_CTRL: reso_cc_ff   <= csr_wdata;
            default: ;  // unused indexes ignored
         endcase
      end
   end

   // input register, parser state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         status_ff    <= '0;
         first_ff     <= '0;
         count_ff     <= 1'b0;
         two_ff       <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            status_ff <= status_in;
            first_ff  <= first_in;
            count_ff  <= count_in;
            two_ff    <= two_in;
            if (fire) begin
               out_valid_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && fire) begin
         evt_ff <= evt_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mrsd_checker.sv =====
`default_nettype none
module mrsd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [mrsd_pkg::RSP_W-1:0]    rsp_tdata
);

   // stalled transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // controller events carry no note number
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != mrsd_pkg::KIND_NOTE_OFF) &&
      (rsp_tdata[2:0] != mrsd_pkg::KIND_NOTE_ON) |-> rsp_tdata[13:7] == '0)
      else $error("note number on a controller event");

   // waveform code is one of three bands
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == mrsd_pkg::KIND_WAVEFORM)
      |-> rsp_tdata[20:14] <= mrsd_pkg::WAVE_TRI)
      else $error("waveform code out of range");

   // an event needs at least one data byte taken in before it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("event without a preceding byte");

endmodule

bind midi_running_status_decoder mrsd_checker u_mrsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== tb/midi_running_status_decoder_checker.sv =====
`timescale 1ns / 100ps

module midi_running_status_decoder_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [mrsd_pkg::RSP_W-1:0]      rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [mrsd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [mrsd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                   mismatch_count,
   output int                                   pending_events,
   output int                                   events_seen
);
   import mrsd_pkg::*;

   // mirrored registers
   logic              cfg_omni;
   logic [CHAN_W-1:0] cfg_listen;
   logic [CTRL_W-1:0] cfg_wave;
   logic [CTRL_W-1:0] cfg_cutoff;
   logic [CTRL_W-1:0] cfg_resonance;

   // parser state
   logic [BYTE_W-1:0] running_status;
   logic [DATA_W-1:0] first_data;
   logic [1:0]        data_count;
   logic [1:0]        data_needed;

   event_type predicted_events[$];

   function automatic bit decode_message(input logic [BYTE_W-1:0] status,
                                         input logic [DATA_W-1:0] d0,
                                         input logic [DATA_W-1:0] d1,
                                         output event_type ev);
      logic [3:0] group;
      group   = status[7:4];
      ev      = '0;
      ev.chan = status[3:0];
      if (!cfg_omni && status[3:0] != cfg_listen) return 0;
      if (group == STATUS_NOTE_ON) begin
         ev.note = d0;
         if (d1 == '0) begin
            ev.kind = KIND_NOTE_OFF;
         end else begin
            ev.kind  = KIND_NOTE_ON;
            ev.value = d1;
         end
         return 1;
      end
      if (group == STATUS_NOTE_OFF) begin
         ev.kind  = KIND_NOTE_OFF;
         ev.note  = d0;
         ev.value = d1;
         return 1;
      end
      if (group == STATUS_CTRL) begin
         if (d0 == cfg_wave) begin
            ev.kind  = KIND_WAVEFORM;
            ev.value = (d1 < BAND_SQUARE) ? WAVE_SAW :
                       (d1 < BAND_TRIANGLE) ? WAVE_PULSE : WAVE_TRI;
            return 1;
         end
         if (d0 == cfg_cutoff) begin
            ev.kind  = KIND_CUTOFF;
            ev.value = d1;
            return 1;
         end
         if (d0 == cfg_resonance) begin
            ev.kind  = KIND_RESONANCE;
            ev.value = d1;
            return 1;
         end
         if (d0 == CC_ALL_NOTES_OFF) begin
            ev.kind = KIND_ALL_OFF;
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic bit decode_midi_byte(input logic [BYTE_W-1:0] b, output event_type ev);
      ev = '0;
      if (b[7]) begin
         if (b[7:4] == STATUS_SYSTEM) return 0;
         running_status = b;
         data_count     = 2'd0;
         data_needed    = (b[7:4] == STATUS_PROGRAM || b[7:4] == STATUS_PRESSURE) ? 2'd1 : 2'd2;
         return 0;
      end
      if (running_status == '0) return 0;
      if (data_count == 2'd0) begin
         first_data = b[DATA_W-1:0];
         if (data_needed > 2'd1) begin
            data_count = 2'd1;
            return 0;
         end
         return decode_message(running_status, first_data, '0, ev);
      end
      data_count = 2'd0;
      return decode_message(running_status, first_data, b[DATA_W-1:0], ev);
   endfunction

   always @(posedge clock) begin : watch_proc
      event_type got;
      event_type want;
      event_type ev;
      logic [RSP_W-EVENT_W-1:0] pad;
      if (reset) begin
         cfg_omni       = OMNI_RESET;
         cfg_listen     = LISTEN_RESET;
         cfg_wave       = WAVEFORM_RESET;
         cfg_cutoff     = CUTOFF_RESET;
         cfg_resonance  = RESONANCE_RESET;
         running_status = '0;
         first_data     = '0;
         data_count     = 2'd0;
         data_needed    = 2'd0;
         predicted_events.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_OMNI_MODE:      cfg_omni      = csr_wdata[0];
               CSR_LISTEN_CHANNEL: cfg_listen    = csr_wdata[CHAN_W-1:0];
               CSR_WAVEFORM_CTRL:  cfg_wave      = csr_wdata[CTRL_W-1:0];
               CSR_CUTOFF_CTRL:    cfg_cutoff    = csr_wdata[CTRL_W-1:0];
               CSR_RESONANCE_CTRL: cfg_resonance = csr_wdata[CTRL_W-1:0];
               default: ;
            endcase
         end
         // compare before predicting: a result never leaves on the edge its byte arrives
         if (rsp_tvalid && rsp_tready) begin
            got         = event_type'(rsp_tdata[EVENT_W-1:0]);
            pad         = rsp_tdata[RSP_W-1:EVENT_W];
            events_seen = events_seen + 1;
            if (predicted_events.size() == 0) begin
               $display("%0t: unexpected event, expected none,", $time);
               $display("%0t:   got kind %0d chan %0d note %0d value %0d",
                        $time, got.kind, got.chan, got.note, got.value);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = predicted_events.pop_front();
               if (got !== want || pad !== '0) begin
                  $display("%0t: event mismatch, expected kind %0d chan %0d note %0d value %0d",
                           $time, want.kind, want.chan, want.note, want.value);
                  $display("%0t:   actual kind %0d chan %0d note %0d value %0d pad %0h",
                           $time, got.kind, got.chan, got.note, got.value, pad);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (decode_midi_byte(req_tdata, ev)) predicted_events.push_back(ev);
         end
      end
      pending_events <= predicted_events.size();
   end

endmodule

// ===== tb/midi_running_status_decoder_tb.sv =====
`timescale 1ns / 100ps

module midi_running_status_decoder_tb;
   import mrsd_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;  // slowest legal run is far below this
   localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;       // input register, decode and result register
   localparam int PHASES        = 8;
   localparam int PHASE_BYTES   = 175;

   // status groups with no name in the package, used only as stimulus
   localparam logic [3:0] GROUP_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] GROUP_PITCH_BEND    = 4'hE;
   // an index past the last register
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_events;
   int events_seen;

   // stimulus bookkeeping
   int bytes_sent;
   int config_writes;
   int cycle_count;
   bit quiet;          // no idling on either side
   bit hold_request;   // ask the receiver for a long hold-off

   // shadow of the programmed registers, only to steer the stimulus
   logic              sh_omni;
   logic [CHAN_W-1:0] sh_listen;
   logic [CTRL_W-1:0] sh_wave;
   logic [CTRL_W-1:0] sh_cutoff;
   logic [CTRL_W-1:0] sh_resonance;
   logic [7:0]        last_status;

   logic [7:0] directed_bytes[] = '{
      // data and a system byte before any status: all dropped
      8'h00, 8'h7F, 8'hFF,
      // note on, then running status with velocity zero
      8'h90, 8'h3C, 8'h64, 8'h3C, 8'h00,
      // note off, extreme channel, note and velocity
      8'h8F, 8'h7F, 8'h7F,
      // waveform bands, cutoff, resonance, all notes off under running status
      8'hB0, 8'h4A, 8'h2A, 8'h4A, 8'h2B, 8'h4A, 8'h55,
      8'h47, 8'h00, 8'h48, 8'h7F, 8'h7B, 8'h00,
      // one-byte program change, then aftertouch broken by a clock byte
      8'hC5, 8'h12, 8'hA0, 8'hF8, 8'h10, 8'h20
   };

   midi_running_status_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   midi_running_status_decoder_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_events (pending_events),
      .events_seen    (events_seen)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d events still pending", cycle_count, pending_events);
      $display("midi_running_status_decoder regression: fail");
      $finish;
   end

   // receiver: random ready bursts, one long hold-off on request
   initial begin : receiver_proc
      int hold_count;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // one byte transaction on the request side, with an optional idle burst first
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // drop valid, let every predicted event out, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_events != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // csr_we stays high across back-to-back writes; the caller drops it once at the end
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      config_writes++;
      @(posedge clock);
   endtask

   task automatic program_config(input logic omni, input logic [CHAN_W-1:0] listen,
                                 input logic [CTRL_W-1:0] wave, input logic [CTRL_W-1:0] cutoff,
                                 input logic [CTRL_W-1:0] resonance);
      logic [5:0] junk_hi;
      logic [2:0] junk_lo;
      junk_hi = 6'($urandom_range(0, 63));
      junk_lo = 3'($urandom_range(0, 7));
      // unused high bits carry junk, only the low bits count
      write_csr(CSR_OMNI_MODE, {junk_hi, omni});
      write_csr(CSR_LISTEN_CHANNEL, {junk_lo, listen});
      write_csr(CSR_WAVEFORM_CTRL, wave);
      write_csr(CSR_CUTOFF_CTRL, cutoff);
      write_csr(CSR_RESONANCE_CTRL, resonance);
      @(negedge clock);
      csr_we <= 1'b0;
      sh_omni      = omni;
      sh_listen    = listen;
      sh_wave      = wave;
      sh_cutoff    = cutoff;
      sh_resonance = resonance;
   endtask

   function automatic logic [6:0] pick_data();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'd127;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // controller numbers lean toward the programmed ones so events happen
   function automatic logic [6:0] pick_controller();
      case ($urandom_range(0, 4))
         0:       return sh_wave;
         1:       return sh_cutoff;
         2:       return sh_resonance;
         3:       return CC_ALL_NOTES_OFF;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   // controller values lean toward the waveform band edges
   function automatic logic [6:0] pick_controller_value();
      case ($urandom_range(0, 9))
         0:       return BAND_SQUARE - 7'd1;
         1:       return BAND_SQUARE;
         2:       return BAND_TRIANGLE - 7'd1;
         3:       return BAND_TRIANGLE;
         default: return pick_data();
      endcase
   endfunction

   // system bytes, stray data and truncated messages
   task automatic send_noise();
      logic [3:0] group;
      case ($urandom_range(0, 2))
         0: send_byte({STATUS_SYSTEM, 4'($urandom_range(0, 15))});
         1: begin
            send_byte({1'b0, 7'($urandom_range(0, 127))});
            last_status = '0;
         end
         default: begin
            group = ($urandom_range(0, 1) == 0) ? STATUS_NOTE_ON : STATUS_CTRL;
            send_byte({group, 4'($urandom_range(0, 15))});
            send_byte({1'b0, pick_data()});
            last_status = '0;
         end
      endcase
   endtask

   // a well-formed message with random content, or at times noise, running status taken at random
   task automatic send_random_message();
      int         r;
      logic [3:0] group;
      logic [3:0] chan;
      logic [7:0] status;
      logic [6:0] d0;
      logic [6:0] d1;
      bit         two_bytes;
      r = $urandom_range(0, 99);
      if (r >= 92) begin
         send_noise();
         return;
      end
      if (r < 30)      group = STATUS_NOTE_ON;
      else if (r < 42) group = STATUS_NOTE_OFF;
      else if (r < 70) group = STATUS_CTRL;
      else if (r < 76) group = STATUS_PROGRAM;
      else if (r < 82) group = STATUS_PRESSURE;
      else if (r < 87) group = GROUP_POLY_PRESSURE;
      else             group = GROUP_PITCH_BEND;
      if (!sh_omni && $urandom_range(0, 2) != 0) chan = sh_listen;
      else                                       chan = 4'($urandom_range(0, 15));
      status    = {group, chan};
      two_bytes = !(group == STATUS_PROGRAM || group == STATUS_PRESSURE);
      if (group == STATUS_CTRL) begin
         d0 = pick_controller();
         d1 = pick_controller_value();
      end else begin
         d0 = pick_data();
         d1 = (group == STATUS_NOTE_ON && $urandom_range(0, 4) == 0) ? 7'd0 : pick_data();
      end
      if (status != last_status || $urandom_range(0, 3) == 0) send_byte(status);
      last_status = status;
      send_byte({1'b0, d0});
      if (two_bytes) begin
         // a real-time byte may land between the data bytes
         if ($urandom_range(0, 19) == 0) send_byte({STATUS_SYSTEM, 4'($urandom_range(8, 15))});
         send_byte({1'b0, d1});
      end
   endtask

   // main stimulus
   initial begin : stimulus_proc
      int start_count;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      bytes_sent    = 0;
      config_writes = 0;
      sh_omni      = OMNI_RESET;
      sh_listen    = LISTEN_RESET;
      sh_wave      = WAVEFORM_RESET;
      sh_cutoff    = CUTOFF_RESET;
      sh_resonance = RESONANCE_RESET;
      last_status  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corner cases under the reset configuration
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      last_status = '0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) settle();
         case (p)
            0: ;  // stay on the reset values
            1: program_config(1'b0, 4'd15, 7'd0, 7'd127, CC_ALL_NOTES_OFF);
            2: begin
               // every controller on the same number exercises precedence
               program_config(1'b0, 4'd0, CC_ALL_NOTES_OFF, CC_ALL_NOTES_OFF, CC_ALL_NOTES_OFF);
               write_csr(CSR_UNUSED_INDEX, 7'h55);
               @(negedge clock);
               csr_we <= 1'b0;
            end
            3: program_config(1'b1, 4'd9, 7'd127, 7'd0, 7'd127);
            4: begin
               program_config(1'b1, 4'd3, WAVEFORM_RESET, CUTOFF_RESET, RESONANCE_RESET);
               // the result side stalls for a long stretch while bytes keep coming
               hold_request = 1'b1;
            end
            default: program_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                    7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                    7'($urandom_range(0, 127)));
         endcase
         if (p == PHASES - 1) quiet = 1'b1;
         start_count = bytes_sent;
         while (bytes_sent - start_count < PHASE_BYTES) send_random_message();
      end
      settle();

      $display("sent %0d midi bytes, checked %0d events, %0d register writes in %0d settings",
               bytes_sent, events_seen, config_writes, PHASES);
      $display("covered running status, system and stray bytes, channel filter, band edges");
      if (pending_events != 0) $display("%0d predicted events never arrived", pending_events);
      if (mismatch_count == 0 && pending_events == 0) begin
         $display("midi_running_status_decoder regression: pass");
      end else begin
         $display("midi_running_status_decoder regression: fail");
      end
      $finish;
   end

endmodule
